// ----- hdl/delt_pkg.sv -----
// delt_pkg: shared widths, payload structs and result types for the
// delaunay edge legality test unit. No dependencies.
`default_nettype none

package delt_pkg;

   // coordinate width and the exact widths of every intermediate
   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;   // difference of two coordinates
   localparam int PROD_W     = 2 * DIFF_W;       // product of two differences
   localparam int LIFT_W     = PROD_W + 1;       // sum or difference of two products
   localparam int MIX_W      = DIFF_W + LIFT_W;  // difference times lifted value
   localparam int MINOR_W    = MIX_W + 1;        // difference of two such products
   localparam int TERM_W     = DIFF_W + MINOR_W; // one cofactor term of the determinant
   localparam int DET_W      = TERM_W + 2;       // sum of three terms

   // register stages inside one circle test
   localparam int NUM_STAGES = 5;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type c_x;
      coord_type c_y;
      coord_type d_x;
      coord_type d_y;
      logic      edge_on_border;
      logic      faces_not_triangles;
   } req_type;

   typedef struct packed {
      logic edge_illegal;
      logic degenerate_seen;
   } rsp_type;

   // status of one circle test at the end of its pipeline
   typedef struct packed {
      logic hit;
      logic degen;
   } circ_result_type;

endpackage

`default_nettype wire

// ----- hdl/delt_incircle.sv -----
// delt_incircle: pipelined exact in-circle test of point q against the
// circle through p, r, s, with collinear detection. Depends on delt_pkg.
`default_nettype none

module delt_incircle (
   input  wire logic                                 clock,
   input  wire logic [delt_pkg::NUM_STAGES-1:0]      stage_en,
   input  wire delt_pkg::point_type                  p,
   input  wire delt_pkg::point_type                  r,
   input  wire delt_pkg::point_type                  s,
   input  wire delt_pkg::point_type                  q,
   output delt_pkg::circ_result_type                 result
);
   import delt_pkg::*;

   // stage 1: coordinate differences
   logic signed [DIFF_W-1:0] ox1_ff, oy1_ff, ox2_ff, oy2_ff;
   logic signed [DIFF_W-1:0] adx_ff, ady_ff, bdx_ff, bdy_ff, cdx_ff, cdy_ff;
   logic signed [DIFF_W-1:0] ox1_in, oy1_in, ox2_in, oy2_in;
   logic signed [DIFF_W-1:0] adx_in, ady_in, bdx_in, bdy_in, cdx_in, cdy_in;

   always_comb begin
      ox1_in = DIFF_W'($signed(r.x)) - DIFF_W'($signed(p.x));
      oy1_in = DIFF_W'($signed(r.y)) - DIFF_W'($signed(p.y));
      ox2_in = DIFF_W'($signed(s.x)) - DIFF_W'($signed(p.x));
      oy2_in = DIFF_W'($signed(s.y)) - DIFF_W'($signed(p.y));
      adx_in = DIFF_W'($signed(p.x)) - DIFF_W'($signed(q.x));
      ady_in = DIFF_W'($signed(p.y)) - DIFF_W'($signed(q.y));
      bdx_in = DIFF_W'($signed(r.x)) - DIFF_W'($signed(q.x));
      bdy_in = DIFF_W'($signed(r.y)) - DIFF_W'($signed(q.y));
      cdx_in = DIFF_W'($signed(s.x)) - DIFF_W'($signed(q.x));
      cdy_in = DIFF_W'($signed(s.y)) - DIFF_W'($signed(q.y));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ox1_ff <= ox1_in;
         oy1_ff <= oy1_in;
         ox2_ff <= ox2_in;
         oy2_ff <= oy2_in;
         adx_ff <= adx_in;
         ady_ff <= ady_in;
         bdx_ff <= bdx_in;
         bdy_ff <= bdy_in;
         cdx_ff <= cdx_in;
         cdy_ff <= cdy_in;
      end
   end

   // stage 2: orientation products, lifted squares, 2x2 minor products
   logic signed [PROD_W-1:0] o1_ff, o2_ff, m1_ff, m2_ff;
   logic signed [LIFT_W-1:0] al_ff, bl_ff, cl_ff;
   logic signed [DIFF_W-1:0] adx2_ff, ady2_ff, bdx2_ff, bdy2_ff, cdx2_ff, cdy2_ff;
   logic signed [PROD_W-1:0] o1_in, o2_in, m1_in, m2_in;
   logic signed [LIFT_W-1:0] al_in, bl_in, cl_in;

   always_comb begin
      o1_in = PROD_W'(ox1_ff) * PROD_W'(oy2_ff);
      o2_in = PROD_W'(oy1_ff) * PROD_W'(ox2_ff);
      m1_in = PROD_W'(bdx_ff) * PROD_W'(cdy_ff);
      m2_in = PROD_W'(cdx_ff) * PROD_W'(bdy_ff);
      al_in = LIFT_W'(adx_ff) * LIFT_W'(adx_ff) + LIFT_W'(ady_ff) * LIFT_W'(ady_ff);
      bl_in = LIFT_W'(bdx_ff) * LIFT_W'(bdx_ff) + LIFT_W'(bdy_ff) * LIFT_W'(bdy_ff);
      cl_in = LIFT_W'(cdx_ff) * LIFT_W'(cdx_ff) + LIFT_W'(cdy_ff) * LIFT_W'(cdy_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         o1_ff   <= o1_in;
         o2_ff   <= o2_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         al_ff   <= al_in;
         bl_ff   <= bl_in;
         cl_ff   <= cl_in;
         adx2_ff <= adx_ff;
         ady2_ff <= ady_ff;
         bdx2_ff <= bdx_ff;
         bdy2_ff <= bdy_ff;
         cdx2_ff <= cdx_ff;
         cdy2_ff <= cdy_ff;
      end
   end

   // stage 3: orientation, lifted cross products, third minor
   logic signed [LIFT_W-1:0] orient_ff, minor3_ff, al3_ff;
   logic signed [MIX_W-1:0]  pbc_ff, pcb_ff, qbc_ff, qcb_ff;
   logic signed [DIFF_W-1:0] adx3_ff, ady3_ff;
   logic signed [LIFT_W-1:0] orient_in, minor3_in;
   logic signed [MIX_W-1:0]  pbc_in, pcb_in, qbc_in, qcb_in;

   always_comb begin
      orient_in = LIFT_W'(o1_ff) - LIFT_W'(o2_ff);
      minor3_in = LIFT_W'(m1_ff) - LIFT_W'(m2_ff);
      pbc_in    = MIX_W'(bdy2_ff) * MIX_W'(cl_ff);
      pcb_in    = MIX_W'(cdy2_ff) * MIX_W'(bl_ff);
      qbc_in    = MIX_W'(bdx2_ff) * MIX_W'(cl_ff);
      qcb_in    = MIX_W'(cdx2_ff) * MIX_W'(bl_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         orient_ff <= orient_in;
         minor3_ff <= minor3_in;
         pbc_ff    <= pbc_in;
         pcb_ff    <= pcb_in;
         qbc_ff    <= qbc_in;
         qcb_ff    <= qcb_in;
         al3_ff    <= al_ff;
         adx3_ff   <= adx2_ff;
         ady3_ff   <= ady2_ff;
      end
   end

   // stage 4: the three cofactor terms, orientation sign
   logic signed [TERM_W-1:0]  t1_ff, t2_ff, t3_ff;
   logic                      o_neg_ff, o_zero_ff;
   logic signed [MINOR_W-1:0] u_in, v_in;
   logic signed [TERM_W-1:0]  t1_in, t2_in, t3_in;

   always_comb begin
      u_in  = MINOR_W'(pbc_ff) - MINOR_W'(pcb_ff);
      v_in  = MINOR_W'(qbc_ff) - MINOR_W'(qcb_ff);
      t1_in = TERM_W'(adx3_ff) * TERM_W'(u_in);
      t2_in = TERM_W'(ady3_ff) * TERM_W'(v_in);
      t3_in = TERM_W'(al3_ff) * TERM_W'(minor3_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         t3_ff     <= t3_in;
         o_neg_ff  <= orient_ff[LIFT_W-1];
         o_zero_ff <= (orient_ff == '0);
      end
   end

   // stage 5: determinant sum
   logic signed [DET_W-1:0] det_ff;
   logic                    o_neg5_ff, o_zero5_ff;
   logic signed [DET_W-1:0] det_in;

   always_comb begin
      det_in = DET_W'(t1_ff) - DET_W'(t2_ff) + DET_W'(t3_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         det_ff     <= det_in;
         o_neg5_ff  <= o_neg_ff;
         o_zero5_ff <= o_zero_ff;
      end
   end

   // inside or on: determinant zero or of the orientation's sign
   always_comb begin
      result.degen = o_zero5_ff;
      result.hit   = !o_zero5_ff &&
                     ((det_ff == '0) || (det_ff[DET_W-1] == o_neg5_ff));
   end

endmodule

`default_nettype wire

// ----- hdl/delaunay_edge_legality_test_unit.sv -----
// delaunay_edge_legality_test_unit: top level, two circle-test pipelines,
// valid tracking and the result register. Depends on delt_pkg, delt_incircle.
//
// Usage: an item on the req_ channel carries the four points of the two
// triangles sharing edge A-B (C on one side, D on the other) and the border
// and non-triangle flags. One result item per request leaves on the rsp_
// channel: edge_illegal if D lies inside or on circle ABC or C inside or on
// circle BAD, and degenerate_seen if either triangle is collinear. Either
// flag forces both result bits to zero.
// The item enters the first of the five datapath stages at the accepting edge,
// passes through the remaining stages and then reaches the result register,
// which drives rsp_valid. Throughput is one item per cycle while the receiver
// does not stall; the rate is set by the fully pipelined multiplier stages.
// Each stage holds its item while the stage after it is full and stalled, so
// a stalled receiver fills the pipeline from the end, bubbles are squeezed
// out, and req_ready drops only when every stage holds an item.
// Synchronous reset clears all valid bits; no item is lost or repeated.
`default_nettype none

module delaunay_edge_legality_test_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire delt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output delt_pkg::rsp_type      rsp_data
);
   import delt_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] force_ff;
   logic [NUM_STAGES-1:0] stage_en;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  out_en;
   circ_result_type       res_abc, res_bad;
   point_type             pa, pb, pc, pd;

   // stage enables: a stage loads when it is empty or its successor moves
   always_comb begin
      out_en = !rsp_valid_ff || rsp_ready;
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_en;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      req_ready = stage_en[0];
   end

   // valid bits follow the data
   always_comb begin
      valid_in    = valid_ff;
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
      rsp_valid_in = out_en ? valid_ff[NUM_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // forced-legal flag rides alongside the circle tests
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         force_ff[0] <= req_data.edge_on_border || req_data.faces_not_triangles;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            force_ff[i] <= force_ff[i-1];
         end
      end
   end

   // the two circle tests: D against ABC, C against BAD
   always_comb begin
      pa.x = req_data.a_x;
      pa.y = req_data.a_y;
      pb.x = req_data.b_x;
      pb.y = req_data.b_y;
      pc.x = req_data.c_x;
      pc.y = req_data.c_y;
      pd.x = req_data.d_x;
      pd.y = req_data.d_y;
   end

   delt_incircle u_circ_abc (
      .clock    (clock),
      .stage_en (stage_en),
      .p        (pa),
      .r        (pb),
      .s        (pc),
      .q        (pd),
      .result   (res_abc)
   );

   delt_incircle u_circ_bad (
      .clock    (clock),
      .stage_en (stage_en),
      .p        (pb),
      .r        (pa),
      .s        (pd),
      .q        (pc),
      .result   (res_bad)
   );

   // result register
   always_comb begin
      rsp_data_in.edge_illegal    = !force_ff[NUM_STAGES-1] &&
                                    (res_abc.hit || res_bad.hit);
      rsp_data_in.degenerate_seen = !force_ff[NUM_STAGES-1] &&
                                    (res_abc.degen || res_bad.degen);
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- test/delaunay_edge_legality_test_unit_tb.sv -----
// delaunay_edge_legality_test_unit_tb: self-checking bench for the edge legality
// test unit, with its own exact in-circle predictor and a result scoreboard.
// Depends on delt_pkg and delaunay_edge_legality_test_unit.

module delaunay_edge_legality_test_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import delt_pkg::*;

   localparam int CLK_HIGH     = 6;
   localparam int CLK_LOW      = 6;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BLOCKS = 35;
   localparam int BLOCK_ITEMS   = 50;
   localparam int QUIET_BLOCKS  = 3;
   localparam int PRINT_CAP     = 100;

   // exact signed arithmetic, wide enough for every term of the incircle determinant
   typedef logic signed [127:0] exact_type;

   // expected verdicts for accepted edges, checked in order
   class legality_tracker;
      typedef struct {
         rsp_type     verdict;
         int unsigned edge_no;
      } pending_type;

      pending_type expected_verdicts[$];
      int unsigned edges_seen;
      int unsigned mismatch_count;

      // inside-or-on test of q against circle p, r, s; flat marks a collinear triangle
      function bit circle_hit(input exact_type px, py, rx, ry, sx, sy, qx, qy,
                              output bit flat);
         exact_type orient, adx, ady, bdx, bdy, cdx, cdy, al, bl, cl, det;
         orient = (rx - px) * (sy - py) - (ry - py) * (sx - px);
         flat = (orient == 0);
         if (flat)
            return 1'b0;
         adx = px - qx; ady = py - qy;
         bdx = rx - qx; bdy = ry - qy;
         cdx = sx - qx; cdy = sy - qy;
         al = adx * adx + ady * ady;
         bl = bdx * bdx + bdy * bdy;
         cl = cdx * cdx + cdy * cdy;
         det = adx * (bdy * cl - cdy * bl)
             - ady * (bdx * cl - cdx * bl)
             + al * (bdx * cdy - cdx * bdy);
         return (det == 0) || ((det < 0) == (orient < 0));
      endfunction

      function rsp_type predict_verdict(input req_type e);
         rsp_type v;
         exact_type ax, ay, bx, by, cx, cy, dx, dy;
         bit hit_abc, hit_bad, flat_abc, flat_bad;
         v = '0;
         // border edge or non-triangle face: legal, no circle test
         if (e.edge_on_border || e.faces_not_triangles)
            return v;
         ax = exact_type'($signed(e.a_x)); ay = exact_type'($signed(e.a_y));
         bx = exact_type'($signed(e.b_x)); by = exact_type'($signed(e.b_y));
         cx = exact_type'($signed(e.c_x)); cy = exact_type'($signed(e.c_y));
         dx = exact_type'($signed(e.d_x)); dy = exact_type'($signed(e.d_y));
         hit_abc = circle_hit(ax, ay, bx, by, cx, cy, dx, dy, flat_abc);
         hit_bad = circle_hit(bx, by, ax, ay, dx, dy, cx, cy, flat_bad);
         v.edge_illegal    = hit_abc | hit_bad;
         v.degenerate_seen = flat_abc | flat_bad;
         return v;
      endfunction

      function void note_edge(input req_type e);
         pending_type p;
         p.verdict = predict_verdict(e);
         p.edge_no = edges_seen;
         edges_seen++;
         expected_verdicts = {expected_verdicts, p};
      endfunction

      task report_mismatch(input string what, input int unsigned edge_no,
                           input int got, input int want);
         if (mismatch_count < PRINT_CAP)
            $display("mismatch: %s, edge %0d, got %0d want %0d",
                     what, edge_no, got, want);
         mismatch_count++;
      endtask

      task check_verdict(input rsp_type got);
         pending_type p;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("result with no edge outstanding", edges_seen, 1, 0);
            return;
         end
         p = expected_verdicts.pop_front();
         if (got.edge_illegal !== p.verdict.edge_illegal)
            report_mismatch("edge_illegal", p.edge_no, got.edge_illegal,
                            p.verdict.edge_illegal);
         if (got.degenerate_seen !== p.verdict.degenerate_seen)
            report_mismatch("degenerate_seen", p.edge_no, got.degenerate_seen,
                            p.verdict.degenerate_seen);
      endtask

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   legality_tracker tracker = new;
   bit              idle_enable = 1'b1;
   int unsigned     ready_hold = 0;
   int unsigned     cycle_count = 0;

   delaunay_edge_legality_test_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: ready runs and stall bursts
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 11);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 15);
      end
   end

   // watch both channels for accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_edge(req_data);
         if (rsp_valid && rsp_ready)
            tracker.check_verdict(rsp_data);
      end
   end

   function automatic int pick(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic req_type pack_edge(input int ax, ay, bx, by, cx, cy, dx, dy,
                                         input bit border, input bit nontri);
      req_type e;
      e.a_x = coord_type'(ax); e.a_y = coord_type'(ay);
      e.b_x = coord_type'(bx); e.b_y = coord_type'(by);
      e.c_x = coord_type'(cx); e.c_y = coord_type'(cy);
      e.d_x = coord_type'(dx); e.d_y = coord_type'(dy);
      e.edge_on_border      = border;
      e.faces_not_triangles = nontri;
      return e;
   endfunction

   // lattice points on the circle of radius 5 about the origin
   function automatic void ring_point(input int i, output int x, output int y);
      case (i)
         0:  begin x =  5; y =  0; end
         1:  begin x =  4; y =  3; end
         2:  begin x =  3; y =  4; end
         3:  begin x =  0; y =  5; end
         4:  begin x = -3; y =  4; end
         5:  begin x = -4; y =  3; end
         6:  begin x = -5; y =  0; end
         7:  begin x = -4; y = -3; end
         8:  begin x = -3; y = -4; end
         9:  begin x =  0; y = -5; end
         10: begin x =  3; y = -4; end
         default: begin x = 4; y = -3; end
      endcase
   endfunction

   // random edge: mostly shaped so ties, cocircular and collinear cases come up
   function automatic req_type random_edge();
      int pts[8];
      int kind, ox, oy, s, i, j, ux, uy, k, rx, ry;
      bit border, nontri;
      kind   = pick(0, 9);
      border = ($urandom_range(0, 9) == 0);
      nontri = ($urandom_range(0, 9) == 0);
      if (kind <= 2) begin
         // full range
         for (k = 0; k < 8; k++)
            pts[k] = pick(-32768, 32767);
      end else if (kind <= 4) begin
         // tight cluster, lots of exact ties
         ox = pick(-32760, 32760);
         oy = pick(-32760, 32760);
         for (k = 0; k < 4; k++) begin
            pts[2*k]   = ox + pick(-6, 6);
            pts[2*k+1] = oy + pick(-6, 6);
         end
      end else if (kind <= 7) begin
         // four points on one circle, optionally nudged off it
         s  = ($urandom_range(0, 7) == 0) ? pick(1, 6553) : pick(1, 2000);
         ox = (s > 2000) ? 0 : pick(-20000, 20000);
         oy = (s > 2000) ? 0 : pick(-20000, 20000);
         for (k = 0; k < 4; k++) begin
            ring_point(pick(0, 11), rx, ry);
            pts[2*k]   = ox + s * rx;
            pts[2*k+1] = oy + s * ry;
         end
         if (kind == 7) begin
            pts[6] += pick(-1, 1);
            pts[7] += pick(-1, 1);
         end
      end else begin
         // one triangle collinear, the other random nearby
         ox = pick(-1000, 1000);
         oy = pick(-1000, 1000);
         ux = pick(-50, 50);
         uy = pick(-50, 50);
         i  = pick(-100, 100);
         j  = pick(-100, 100);
         pts[0] = ox;          pts[1] = oy;
         pts[2] = ox + i * ux; pts[3] = oy + i * uy;
         if ($urandom_range(0, 1) == 0) begin
            pts[4] = ox + j * ux;  pts[5] = oy + j * uy;
            pts[6] = pick(-6000, 6000); pts[7] = pick(-6000, 6000);
         end else begin
            pts[4] = pick(-6000, 6000); pts[5] = pick(-6000, 6000);
            pts[6] = ox + j * ux;  pts[7] = oy + j * uy;
         end
      end
      return pack_edge(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5], pts[6], pts[7],
                       border, nontri);
   endfunction

   // offer one item, with an optional idle burst first, and wait for acceptance
   task automatic offer_edge(input req_type e);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= e;
      do @(posedge clock); while (!req_ready);
   endtask

   // main sequence
   initial begin
      int blk, n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: inside, outside, on circle, flags, collinear, extremes
      offer_edge(pack_edge(0, 0, 10, 0, 5, 10, 5, -1, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 0, 5, 10, 5, -30, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 10, 0, 10, 10, 0, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 10, 0, 10, 10, 0, 1, 0));
      offer_edge(pack_edge(0, 0, 10, 10, 0, 10, 10, 0, 0, 1));
      offer_edge(pack_edge(0, 0, 10, 10, 0, 10, 10, 0, 1, 1));
      offer_edge(pack_edge(0, 0, 10, 0, 20, 0, 5, -5, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 0, 3, 4, -7, 0, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 0, 20, 0, -7, 0, 0, 0));
      offer_edge(pack_edge(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_edge(pack_edge(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                           0, 0));
      offer_edge(pack_edge(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768,
                           0, 0));
      offer_edge(pack_edge(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           0, 0));
      offer_edge(pack_edge(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
      offer_edge(pack_edge(-32768, 0, 32767, 0, 0, 1, 0, -1, 0, 0));
      offer_edge(pack_edge(-32768, 0, 32767, 0, 0, 32767, 0, -32768, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 0, 5, 1, 5, -20, 0, 0));
      offer_edge(pack_edge(0, 0, 10, 0, 5, -10, 5, 1, 0, 0));
      offer_edge(pack_edge(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846,
                           0, 0));
      offer_edge(pack_edge(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845,
                           0, 0));
      offer_edge(pack_edge(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767,
                           1, 1));
      offer_edge(pack_edge(-1, -1, 1, 1, -1, 1, 1, -1, 0, 0));
      offer_edge(pack_edge(1, 0, 0, 1, -1, 0, 0, -1, 0, 0));

      // random blocks, some without idling, the tail always at full rate
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         idle_enable = (blk < RANDOM_BLOCKS - QUIET_BLOCKS) && ($urandom_range(0, 3) != 0);
         for (n = 0; n < BLOCK_ITEMS; n++)
            offer_edge(random_edge());
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
